// ===== rtl/bmf_pkg.sv =====
// bmf_pkg: types, status codes and register indexes of the broadcast message queue
// used by the core and the checker under rtl; depends on nothing

package bmf_pkg;

  // fixed field widths
  localparam int ID_BITS       = 8;
  localparam int IDX_BITS      = 3;
  localparam int PAYLOAD_BITS  = 32;
  localparam int STATUS_BITS   = 3;
  localparam int MASK_BITS     = 8;

  // parameter defaults
  localparam int DEF_DEPTH     = 16;
  localparam int DEF_RECEIVERS = 8;

  // register file layout
  localparam int PADDR_BITS    = 3;
  localparam int PDATA_BITS    = 32;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_PEEK = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_SENT      = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_NOTHING   = 3'd3,
    ST_READ      = 3'd4
  } status_t;

  typedef enum logic {
    REG_ACTIVE_MASK  = 1'b0,
    REG_BROADCAST_ID = 1'b1
  } reg_idx_t;

  // request transaction
  typedef struct packed {
    cmd_t                    cmd;
    logic [ID_BITS-1:0]      msg_id;
    logic [IDX_BITS-1:0]     dest;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [IDX_BITS-1:0]     receiver;
  } req_t;

  // response transaction
  typedef struct packed {
    status_t                 status;
    logic [ID_BITS-1:0]      out_msg_id;
    logic [IDX_BITS-1:0]     out_dest;
    logic [PAYLOAD_BITS-1:0] out_payload;
  } rsp_t;

  // one stored message
  typedef struct packed {
    logic [ID_BITS-1:0]      msg_id;
    logic [IDX_BITS-1:0]     dest;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ===== rtl/bmf_ram.sv =====
// bmf_ram: generic simple dual-port ram, one write port, one registered read port
// read during write to the same address returns the old data; no dependencies

module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/broadcast_message_fifo_core.sv =====
// broadcast_message_fifo_core: ring message queue shared by several receivers
// depends on bmf_pkg and bmf_ram
//
//   channel | signals                          | direction | transaction
//   --------+----------------------------------+-----------+--------------------------
//   req     | req_valid, req_ready, req        | in        | send or peek command
//   rsp     | rsp_valid, rsp_ready, rsp        | out       | status and delivered entry
//   apb     | psel, penable, pwrite, paddr ... | in/out    | active_mask, broadcast_id
//
// every command is resolved in the cycle it is accepted; its response sits in the
// output register in the next cycle, so one transaction per cycle is sustained
// while rsp_ready is high. the head entry is prefetched from the message ram each cycle
// (registered read port plus a write bypass), so a peek is resolved in the cycle it is taken.
// a stalled response blocks new commands only while it is still held.
// rst is synchronous; no clearing pass is needed after it.

module broadcast_message_fifo_core
  import bmf_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int RECEIVERS = DEF_RECEIVERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // state
  logic [MASK_BITS-1:0] active_mask;
  logic [ID_BITS-1:0]   broadcast_id;
  logic [AW-1:0]        head_index, head_index_next;
  logic [AW-1:0]        tail_index, tail_index_next;
  logic [CW-1:0]        fill_count, fill_count_next;
  logic [RECEIVERS-1:0] readers_seen, readers_seen_next;
  logic                 byp_valid;
  entry_t               byp_data;

  // combinational
  logic                 accept;
  logic                 ram_we;
  entry_t               ram_wdata;
  entry_t               ram_rdata;
  entry_t               head_entry;
  logic [RECEIVERS-1:0] rx_bit;
  logic [RECEIVERS-1:0] want_mask;
  logic [RECEIVERS-1:0] seen_or;
  logic                 rx_valid;
  logic                 retire;
  rsp_t                 rsp_next;

  assign pready    = 1'b1;
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // apb register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask  <= '1;
      broadcast_id <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_ACTIVE_MASK:  active_mask  <= pwdata[MASK_BITS-1:0];
        REG_BROADCAST_ID: broadcast_id <= pwdata[ID_BITS-1:0];
        default: ;
      endcase
    end
  end

  // apb register reads
  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_ACTIVE_MASK:  prdata = PDATA_BITS'(active_mask);
      REG_BROADCAST_ID: prdata = PDATA_BITS'(broadcast_id);
      default:          prdata = '0;
    endcase
  end

  // head entry: ram data unless the last cycle wrote the address being read
  assign head_entry = byp_valid ? byp_data : ram_rdata;

  // receiver one-hot and the set that must read a broadcast
  always_comb begin
    for (int i = 0; i < RECEIVERS; i++) begin
      rx_bit[i]    = (32'(req.receiver) == i);
      want_mask[i] = (i < MASK_BITS) ? active_mask[i % MASK_BITS] : 1'b0;
    end
  end

  assign rx_valid = (32'(req.receiver) < RECEIVERS);
  assign seen_or  = readers_seen | rx_bit;

  // command decode and queue update
  always_comb begin
    head_index_next   = head_index;
    tail_index_next   = tail_index;
    fill_count_next   = fill_count;
    readers_seen_next = readers_seen;
    ram_we            = 1'b0;
    ram_wdata         = '{msg_id: req.msg_id, dest: req.dest, payload: req.payload};
    retire            = 1'b0;
    rsp_next          = '{status: ST_NOTHING, out_msg_id: '0, out_dest: '0,
                          out_payload: '0};

    if (accept) begin
      case (req.cmd)
        CMD_SEND: begin
          if (fill_count == FULL_CNT) begin
            rsp_next.status = ST_FULL;
          end else begin
            ram_we          = 1'b1;
            tail_index_next = (tail_index == LAST_IDX) ? '0 : tail_index + 1'b1;
            fill_count_next = fill_count + 1'b1;
            rsp_next.status = ST_SENT;
          end
        end
        CMD_PEEK: begin
          if (fill_count != '0 && rx_valid) begin
            if (head_entry.msg_id == broadcast_id) begin
              if ((readers_seen & rx_bit) != '0) begin
                rsp_next.status = ST_READ;
              end else begin
                rsp_next.status   = ST_DELIVERED;
                readers_seen_next = seen_or;
                retire            = (seen_or == want_mask);
              end
            end else if (32'(head_entry.dest) == 32'(req.receiver)) begin
              rsp_next.status = ST_DELIVERED;
              retire          = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (rsp_next.status == ST_DELIVERED) begin
        rsp_next.out_msg_id  = head_entry.msg_id;
        rsp_next.out_dest    = head_entry.dest;
        rsp_next.out_payload = head_entry.payload;
      end

      // retiring the head clears its reader set for the next entry
      if (retire) begin
        readers_seen_next = '0;
        head_index_next   = (head_index == LAST_IDX) ? '0 : head_index + 1'b1;
        fill_count_next   = fill_count - 1'b1;
      end
    end
  end

  // queue pointers and head reader set
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index   <= '0;
      tail_index   <= '0;
      fill_count   <= '0;
      readers_seen <= '0;
      byp_valid    <= 1'b0;
    end else begin
      head_index   <= head_index_next;
      tail_index   <= tail_index_next;
      fill_count   <= fill_count_next;
      readers_seen <= readers_seen_next;
      byp_valid    <= ram_we && (tail_index == head_index_next);
    end
  end

  // bypass data for a send into the slot about to be the head
  always_ff @(posedge clk) begin
    byp_data <= ram_wdata;
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_ready) begin
      rsp_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // message store, read at the next head every cycle
  bmf_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_index),
    .wdata (ram_wdata),
    .raddr (head_index_next),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/bmf_checker.sv =====
// bmf_checker: port level assertions for broadcast_message_fifo_core
// depends on bmf_pkg; bound to the top level at the end of this file

module bmf_checker
  import bmf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // no response right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a held response stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // commands are taken whenever the output register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid || rsp_ready |-> req_ready)
    else $error("request stalled with free output register");

  // each accepted command gives a response in the next cycle
  a_one_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted command produced no response");

  // entry fields are zero unless delivered
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_DELIVERED |->
      rsp.out_msg_id == '0 && rsp.out_dest == '0 && rsp.out_payload == '0)
    else $error("entry fields set on non-delivered response");

endmodule

bind broadcast_message_fifo_core bmf_checker u_bmf_checker (.*);
